// ===== design/rtds_pkg.sv =====
// Types and constants shared by the ready-to-drive supervisor modules.
`default_nettype none
package rtds_pkg;

    // Item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_TX_ID       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_REG  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_REG   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLTAGE_REG = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PENDING     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUZZER      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_REISSUE     = 3'd7;

    // Status word bit positions
    localparam int STATUS_ENABLE_BIT = 0;
    localparam int STATUS_READY_BIT  = 2;
    localparam int STATUS_FAULT_BIT  = 6;

    localparam logic [3:0] MIN_FRAME_LEN = 4'd3;

    typedef struct packed {
        logic        func;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  reg_byte;
        logic [15:0] data_word;
        logic        brake_pressed;
        logic        button_pressed;
    } in_t;

    typedef struct packed {
        logic               ready_out;
        logic               fault_out;
        logic               pending_out;
        logic               buzzer_out;
        logic [15:0]        status_out;
        logic signed [15:0] speed_out;
        logic [15:0]        bus_voltage_out;
        logic               enable_cmd;
        logic               reissue_cmd;
    } out_t;

    typedef struct packed {
        logic [10:0] inverter_tx_id;
        logic [7:0]  status_reg;
        logic [7:0]  speed_reg;
        logic [7:0]  bus_voltage_reg;
        logic [15:0] hold_ticks;
        logic [15:0] pending_timeout_ticks;
        logic [15:0] buzzer_ticks;
        logic [15:0] reissue_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/rtds_cfg.sv =====
// Configuration register file of the ready-to-drive supervisor.
`default_nettype none
module rtds_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [rtds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [rtds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rtds_pkg::cfg_t                      cfg
);

    rtds_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inverter_tx_id        <= 11'd385;
            cfg_reg.status_reg            <= 8'd64;
            cfg_reg.speed_reg             <= 8'd48;
            cfg_reg.bus_voltage_reg       <= 8'd235;
            cfg_reg.hold_ticks            <= 16'd1000;
            cfg_reg.pending_timeout_ticks <= 16'd2000;
            cfg_reg.buzzer_ticks          <= 16'd3000;
            cfg_reg.reissue_ticks         <= 16'd5000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rtds_pkg::CFG_TX_ID:       cfg_reg.inverter_tx_id <= cfg_wdata[10:0];
                rtds_pkg::CFG_STATUS_REG:  cfg_reg.status_reg <= cfg_wdata[7:0];
                rtds_pkg::CFG_SPEED_REG:   cfg_reg.speed_reg <= cfg_wdata[7:0];
                rtds_pkg::CFG_VOLTAGE_REG: cfg_reg.bus_voltage_reg <= cfg_wdata[7:0];
                rtds_pkg::CFG_HOLD:        cfg_reg.hold_ticks <= cfg_wdata;
                rtds_pkg::CFG_PENDING:     cfg_reg.pending_timeout_ticks <= cfg_wdata;
                rtds_pkg::CFG_BUZZER:      cfg_reg.buzzer_ticks <= cfg_wdata;
                rtds_pkg::CFG_REISSUE:     cfg_reg.reissue_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== design/rtds_core.sv =====
// Supervisor state and the single-pass update for one tick or frame.
`default_nettype none
module rtds_core (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    fire,
    input  wire rtds_pkg::in_t  item,
    input  wire rtds_pkg::cfg_t cfg,
    output rtds_pkg::out_t result
);

    logic        ready_reg, fault_reg, pending_reg, holding_reg, buzzer_reg;
    logic [15:0] hold_cnt_reg, pend_cnt_reg, buzz_cnt_reg, reissue_cnt_reg;
    logic [15:0] status_reg, speed_reg, voltage_reg;

    logic        ready_next, fault_next, pending_next, holding_next, buzzer_next;
    logic [15:0] hold_cnt_next, pend_cnt_next, buzz_cnt_next, reissue_cnt_next;
    logic [15:0] status_next, speed_next, voltage_next;
    logic        enable_cmd, reissue_cmd;
    logic [15:0] buzz_inc;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    always_comb begin
        ready_next       = ready_reg;
        fault_next       = fault_reg;
        pending_next     = pending_reg;
        holding_next     = holding_reg;
        buzzer_next      = buzzer_reg;
        hold_cnt_next    = hold_cnt_reg;
        pend_cnt_next    = pend_cnt_reg;
        buzz_cnt_next    = buzz_cnt_reg;
        reissue_cnt_next = reissue_cnt_reg;
        status_next      = status_reg;
        speed_next       = speed_reg;
        voltage_next     = voltage_reg;
        enable_cmd       = 1'b0;
        reissue_cmd      = 1'b0;
        buzz_inc         = sat_inc(buzz_cnt_reg);

        if (item.func == rtds_pkg::FUNC_FRAME) begin
            if (item.frame_id == cfg.inverter_tx_id &&
                item.frame_len >= rtds_pkg::MIN_FRAME_LEN) begin
                if (item.reg_byte == cfg.status_reg) begin
                    status_next = item.data_word;
                    fault_next  = item.data_word[rtds_pkg::STATUS_FAULT_BIT];
                    if (item.data_word[rtds_pkg::STATUS_FAULT_BIT]) begin
                        ready_next    = 1'b0;
                        pending_next  = 1'b0;
                        pend_cnt_next = '0;
                        buzzer_next   = 1'b0;
                        buzz_cnt_next = '0;
                    end else if (item.data_word[rtds_pkg::STATUS_ENABLE_BIT] &&
                                 item.data_word[rtds_pkg::STATUS_READY_BIT]) begin
                        if (!ready_reg) begin
                            ready_next    = 1'b1;
                            pending_next  = 1'b0;
                            pend_cnt_next = '0;
                            buzzer_next   = 1'b1;
                            buzz_cnt_next = '0;
                        end
                    end else if (ready_reg) begin
                        ready_next    = 1'b0;
                        pend_cnt_next = '0;
                        buzzer_next   = 1'b0;
                        buzz_cnt_next = '0;
                    end
                end else if (item.reg_byte == cfg.speed_reg) begin
                    speed_next = item.data_word;
                end else if (item.reg_byte == cfg.bus_voltage_reg) begin
                    voltage_next = item.data_word;
                end
            end
        end else begin
            if (pending_reg) begin
                if (pend_cnt_reg >= cfg.pending_timeout_ticks) begin
                    pending_next  = 1'b0;
                    pend_cnt_next = '0;
                end else begin
                    pend_cnt_next = sat_inc(pend_cnt_reg);
                end
            end
            if (reissue_cnt_reg >= cfg.reissue_ticks) begin
                reissue_cmd      = 1'b1;
                reissue_cnt_next = '0;
            end else begin
                reissue_cnt_next = sat_inc(reissue_cnt_reg);
            end
            if (buzzer_reg) begin
                if (buzz_inc >= cfg.buzzer_ticks) begin
                    buzzer_next   = 1'b0;
                    buzz_cnt_next = '0;
                end else begin
                    buzz_cnt_next = buzz_inc;
                end
            end
            if (holding_reg) begin
                hold_cnt_next = sat_inc(hold_cnt_reg);
            end
            // pending_next here already reflects the timeout above
            if (!ready_reg) begin
                if (fault_reg || pending_next || !item.brake_pressed ||
                    !item.button_pressed) begin
                    holding_next = 1'b0;
                end else begin
                    if (!holding_reg) begin
                        holding_next  = 1'b1;
                        hold_cnt_next = '0;
                    end
                    if (hold_cnt_next >= cfg.hold_ticks) begin
                        enable_cmd    = 1'b1;
                        pending_next  = 1'b1;
                        pend_cnt_next = '0;
                        holding_next  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg       <= 1'b0;
            fault_reg       <= 1'b0;
            pending_reg     <= 1'b0;
            holding_reg     <= 1'b0;
            buzzer_reg      <= 1'b0;
            hold_cnt_reg    <= '0;
            pend_cnt_reg    <= '0;
            buzz_cnt_reg    <= '0;
            reissue_cnt_reg <= '0;
            status_reg      <= '0;
            speed_reg       <= '0;
            voltage_reg     <= '0;
        end else if (fire) begin
            ready_reg       <= ready_next;
            fault_reg       <= fault_next;
            pending_reg     <= pending_next;
            holding_reg     <= holding_next;
            buzzer_reg      <= buzzer_next;
            hold_cnt_reg    <= hold_cnt_next;
            pend_cnt_reg    <= pend_cnt_next;
            buzz_cnt_reg    <= buzz_cnt_next;
            reissue_cnt_reg <= reissue_cnt_next;
            status_reg      <= status_next;
            speed_reg       <= speed_next;
            voltage_reg     <= voltage_next;
        end
    end

    always_comb begin
        result.ready_out       = ready_next;
        result.fault_out       = fault_next;
        result.pending_out     = pending_next;
        result.buzzer_out      = buzzer_next;
        result.status_out      = status_next;
        result.speed_out       = speed_next;
        result.bus_voltage_out = voltage_next;
        result.enable_cmd      = enable_cmd;
        result.reissue_cmd     = reissue_cmd;
    end

endmodule
`default_nettype wire

// ===== design/ready_to_drive_supervisor.sv =====
// Ready-to-drive supervisor: top level with input and result registers.
//
// Usage:
//   s_valid/s_ready/s_data carry items: a 1 ms tick (func = 0) with the brake
//   and button levels, or a received CAN frame (func = 1). Every accepted item
//   yields exactly one result beat on m_valid/m_ready/m_data with the flags,
//   stored status/speed/voltage words and the enable/reissue command pulses.
//   m_valid rises once an accepted item has passed the input register and then
//   the result register. One item per cycle is sustained while m_ready stays
//   high. The single-pass flag and counter update sits between the two registers.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more item; s_ready drops only when both
//   are full.
//   cfg_we/cfg_addr/cfg_wdata write one configuration register per cycle;
//   write only while no item is in flight.
//   aresetn (synchronous, active low) clears all flags, counters and stored
//   words, empties both registers and loads the default configuration.
`default_nettype none
module ready_to_drive_supervisor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire rtds_pkg::in_t                   s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output rtds_pkg::out_t                       m_data,
    input  wire logic                            cfg_we,
    input  wire logic [rtds_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [rtds_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic           in_valid_reg;
    rtds_pkg::in_t  in_data_reg;
    logic           out_valid_reg;
    rtds_pkg::out_t out_data_reg;
    rtds_pkg::cfg_t cfg;
    rtds_pkg::out_t core_result;
    logic           out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;

    rtds_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtds_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (out_load),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // confirmation clears a pending request, and requests are only raised while not ready
    a_ready_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.ready_out && m_data.pending_out))
        else $error("ready and pending both set");

    // buzzer only sounds while ready is held
    a_buzzer_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.buzzer_out) |-> m_data.ready_out)
        else $error("buzzer without ready");

    a_enable_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.enable_cmd) |-> (m_data.pending_out && !m_data.ready_out))
        else $error("enable command without pending request");

    // a result beat is only produced from a held input item
    a_load_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(in_valid_reg))
        else $error("result beat without input item");
`endif

endmodule
`default_nettype wire
